@@ rtl/stream_substring_replace_assert.svh @@
// ------------------------------------------------------------------------
// Assertion macros for the substring replace block
// Immediate-cycle and next-cycle implication checks with reset disable.
// ------------------------------------------------------------------------
`ifndef STREAM_SUBSTRING_REPLACE_ASSERT_SVH
`define STREAM_SUBSTRING_REPLACE_ASSERT_SVH

// check cons in the same cycle as ante
`define SSR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssr check failed");

// check cons in the cycle after ante
`define SSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssr check failed");

`endif

@@ rtl/ssr_pkg.sv @@
// ------------------------------------------------------------------------
// Substring replace package
// Sizes, register indexes, command word type shared by the front, queue, back and top.
// ------------------------------------------------------------------------
package ssr_pkg;

    localparam int MAX_PATTERN_BYTES     = 16;
    localparam int MAX_REPLACEMENT_BYTES = 16;
    localparam int CFG_DATA_W            = 64;
    localparam int CFG_IDX_W             = 3;
    localparam int LEN_W                 = 5;
    localparam int FILL_W                = $clog2(MAX_PATTERN_BYTES);
    localparam int QUEUE_DEPTH           = 2;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    localparam logic [CFG_IDX_W-1:0] REG_PAT_LO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_HI  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REP_LO  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REP_HI  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REP_LEN = 3'd5;

    typedef logic [MAX_PATTERN_BYTES-1:0][7:0] t_bytes;

    typedef struct packed {
        t_bytes             bytes;
        logic               use_repl;
        logic [LEN_W-1:0]   count;
        logic               fin;
    } t_cmd;

endpackage

@@ rtl/stream_substring_replace.sv @@
// ------------------------------------------------------------------------
// Streaming substring replace
// Replaces leftmost non-overlapping pattern occurrences in a byte stream.
//
//  channel  direction  handshake                  payload
//  input    in         i_in_valid / o_in_stall    i_text_byte, i_final_byte
//  output   out        o_out_valid / i_out_stall  o_out_byte, o_out_byte_present,
//                                                 o_out_run_end, o_out_stream_end
//  config   in         i_cfg_wr_en                i_cfg_index, i_cfg_data
//
// One text word is accepted per cycle while the two-entry command queue has room.
// The back end emits one result word per cycle unless stalled.
// A text word's first result passes through the queue and then the output register.
// Synchronous active-low reset restores the register defaults and empties the window.
// Output stall holds the output register; the queue then fills and raises o_in_stall.
// ------------------------------------------------------------------------
module stream_substring_replace (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [ssr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ssr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_text_byte,
    input  logic                           i_final_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [7:0]                     o_out_byte,
    output logic                           o_out_byte_present,
    output logic                           o_out_run_end,
    output logic                           o_out_stream_end
);
    import ssr_pkg::*;

    logic   accept;
    logic   push;
    logic   pop;
    logic   full;
    logic   empty;
    t_cmd   cmd;
    t_cmd   head;
    t_bytes repl;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    ssr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_text_byte  (i_text_byte),
        .i_final_byte (i_final_byte),
        .o_push       (push),
        .o_cmd        (cmd),
        .o_repl       (repl)
    );

    ssr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    ssr_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_head             (head),
        .i_empty            (empty),
        .i_repl             (repl),
        .i_out_stall        (i_out_stall),
        .o_pop              (pop),
        .o_out_valid        (o_out_valid),
        .o_out_byte         (o_out_byte),
        .o_out_byte_present (o_out_byte_present),
        .o_out_run_end      (o_out_run_end),
        .o_out_stream_end   (o_out_stream_end)
    );

endmodule

@@ rtl/ssr_queue.sv @@
// ------------------------------------------------------------------------
// Command queue
// Short FIFO of command words between the front and the back.
// ------------------------------------------------------------------------
module ssr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ssr_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output ssr_pkg::t_cmd o_head,
    output logic          o_full,
    output logic          o_empty
);
    import ssr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

@@ rtl/ssr_front.sv @@
// ------------------------------------------------------------------------
// Front end
// Holds configuration and the match window, classifies each text byte
// and issues one command word per byte that yields results or ends the stream.
// ------------------------------------------------------------------------
module ssr_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [ssr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ssr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_accept,
    input  logic [7:0]                     i_text_byte,
    input  logic                           i_final_byte,
    output logic                           o_push,
    output ssr_pkg::t_cmd                  o_cmd,
    output ssr_pkg::t_bytes                o_repl
);
    import ssr_pkg::*;

    logic [CFG_DATA_W-1:0] r_pat_lo;
    logic [CFG_DATA_W-1:0] r_pat_hi;
    logic [LEN_W-1:0]      r_pat_len;
    logic [CFG_DATA_W-1:0] r_rep_lo;
    logic [CFG_DATA_W-1:0] r_rep_hi;
    logic [LEN_W-1:0]      r_rep_len;

    t_bytes                r_win;
    t_bytes                n_win;
    logic [FILL_W-1:0]     r_fill;
    logic [FILL_W-1:0]     n_fill;

    t_bytes                pat;
    t_bytes                w_ins;
    logic [LEN_W-1:0]      plen;
    logic [LEN_W-1:0]      rlen;
    logic [LEN_W-1:0]      fill_inc;
    logic                  is_nl;
    logic                  full;
    logic                  match;

    assign pat    = {r_pat_hi, r_pat_lo};
    assign o_repl = {r_rep_hi, r_rep_lo};

    always_comb begin
        if (r_pat_len == '0) begin
            plen = LEN_W'(1);
        end else if (r_pat_len > LEN_W'(MAX_PATTERN_BYTES)) begin
            plen = LEN_W'(MAX_PATTERN_BYTES);
        end else begin
            plen = r_pat_len;
        end
        if (r_rep_len > LEN_W'(MAX_REPLACEMENT_BYTES)) begin
            rlen = LEN_W'(MAX_REPLACEMENT_BYTES);
        end else begin
            rlen = r_rep_len;
        end
    end

    assign fill_inc = {1'b0, r_fill} + LEN_W'(1);
    assign is_nl    = (i_text_byte == NEWLINE_CODE);
    assign full     = !is_nl && (fill_inc == plen);

    always_comb begin
        match = 1'b1;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
            w_ins[i] = (FILL_W'(i) == r_fill) ? i_text_byte : r_win[i];
        end
        for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
            if ((LEN_W'(i) < plen) && (w_ins[i] != pat[i])) begin
                match = 1'b0;
            end
        end
    end

    always_comb begin
        o_cmd.bytes    = w_ins;
        o_cmd.use_repl = 1'b0;
        o_cmd.fin      = i_final_byte;
        n_win          = r_win;
        n_fill         = r_fill;
        if (is_nl) begin
            o_cmd.count = fill_inc;
            n_fill      = '0;
        end else if (full && match) begin
            o_cmd.use_repl = 1'b1;
            o_cmd.count    = rlen;
            n_fill         = '0;
        end else if (full) begin
            o_cmd.count = i_final_byte ? plen : LEN_W'(1);
            for (int i = 0; i < MAX_PATTERN_BYTES - 1; i++) begin
                n_win[i] = w_ins[i+1];
            end
            n_win[MAX_PATTERN_BYTES-1] = w_ins[MAX_PATTERN_BYTES-1];
            n_fill = FILL_W'(plen - LEN_W'(1));
        end else begin
            o_cmd.count = i_final_byte ? fill_inc : '0;
            n_win       = w_ins;
            n_fill      = fill_inc[FILL_W-1:0];
        end
        if (i_final_byte) begin
            n_fill = '0;
        end
    end

    assign o_push = i_accept && ((o_cmd.count != '0) || i_final_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_pat_len <= LEN_W'(1);
            r_rep_lo  <= '0;
            r_rep_hi  <= '0;
            r_rep_len <= '0;
            r_fill    <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_PAT_LO:  r_pat_lo  <= i_cfg_data;
                REG_PAT_HI:  r_pat_hi  <= i_cfg_data;
                REG_PAT_LEN: begin
                    r_pat_len <= i_cfg_data[LEN_W-1:0];
                    r_fill    <= '0;
                end
                REG_REP_LO:  r_rep_lo  <= i_cfg_data;
                REG_REP_HI:  r_rep_hi  <= i_cfg_data;
                REG_REP_LEN: r_rep_len <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end else if (i_accept) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_win <= n_win;
        end
    end

endmodule

@@ rtl/ssr_back.sv @@
// ------------------------------------------------------------------------
// Back end
// Expands the head command word into result words, one per cycle
// while the output is not stalled, through a registered output stage.
// ------------------------------------------------------------------------
module ssr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ssr_pkg::t_cmd   i_head,
    input  logic            i_empty,
    input  ssr_pkg::t_bytes i_repl,
    input  logic            i_out_stall,
    output logic            o_pop,
    output logic            o_out_valid,
    output logic [7:0]      o_out_byte,
    output logic            o_out_byte_present,
    output logic            o_out_run_end,
    output logic            o_out_stream_end
);
    import ssr_pkg::*;

    logic              r_valid;
    logic [7:0]        r_byte;
    logic              r_present;
    logic              r_run_end;
    logic              r_stream_end;
    logic [FILL_W-1:0] r_idx;
    logic              load;
    logic              last;
    logic              is_marker;

    assign load      = !i_empty && (!r_valid || !i_out_stall);
    assign is_marker = (i_head.count == '0);
    assign last      = is_marker || ({1'b0, r_idx} == (i_head.count - LEN_W'(1)));
    assign o_pop     = load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last ? '0 : r_idx + 1'b1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (is_marker) begin
                r_byte <= '0;
            end else if (i_head.use_repl) begin
                r_byte <= i_repl[r_idx];
            end else begin
                r_byte <= i_head.bytes[r_idx];
            end
            r_present    <= !is_marker;
            r_run_end    <= last;
            r_stream_end <= last && i_head.fin;
        end
    end

    assign o_out_valid        = r_valid;
    assign o_out_byte         = r_byte;
    assign o_out_byte_present = r_present;
    assign o_out_run_end      = r_run_end;
    assign o_out_stream_end   = r_stream_end;

endmodule

@@ rtl/ssr_checker.sv @@
// ------------------------------------------------------------------------
// Port checker
// Output-side checks on the substring replace top level, bound in.
// ------------------------------------------------------------------------
`include "stream_substring_replace_assert.svh"

module ssr_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       o_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] o_out_byte,
    input  logic       o_out_byte_present,
    input  logic       o_out_run_end,
    input  logic       o_out_stream_end
);

    `SSR_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_byte) && $stable(o_out_byte_present) && $stable(o_out_run_end) && $stable(o_out_stream_end))
    `SSR_ASSERT_SAME(a_marker_ends, i_clk, i_rst_n, o_out_valid && !o_out_byte_present, o_out_run_end && o_out_stream_end)
    `SSR_ASSERT_SAME(a_stream_run, i_clk, i_rst_n, o_out_valid && o_out_stream_end, o_out_run_end)
    `SSR_ASSERT_SAME(a_marker_zero, i_clk, i_rst_n, o_out_valid && !o_out_byte_present, o_out_byte == 8'd0)

endmodule

bind stream_substring_replace ssr_checker u_ssr_checker (.*);
